@@ src/puregp_pkg.sv @@
`default_nettype none
package puregp_pkg;
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_ACK   = 2'd3;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OADDR  = 3'd3;
  localparam logic [2:0] REG_ODATA  = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [15:0] STARTUP_DEFAULT = 16'd29658;
  localparam logic [8:0]  DOTS_LAST   = 9'd340;
  localparam logic [8:0]  LINES_LAST  = 9'd261;
  localparam logic [8:0]  VBLANK_LINE = 9'd241;
  localparam logic [8:0]  PRE_LINE    = 9'd261;
  localparam logic [8:0]  RELOAD_DOT  = 9'd304;
  localparam logic [8:0]  SKIP_DOT    = 9'd339;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] register_select;
    logic [7:0] write_data;
    logic [7:0] pattern_data;
    logic [1:0] nametable_mirroring;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic [14:0] vram_address;
    logic [8:0]  scanline;
    logic [8:0]  dot;
    logic        parity;
  } rsp_t;

  // memory port request from sequencer to store
  typedef struct packed {
    logic       oam_we;
    logic [7:0] sprite_addr;
    logic       nt_we;
    logic [10:0] nt_addr;
    logic       pal_we;
    logic [4:0] pal_addr;
    logic [7:0] wdata;
  } memreq_t;

  function automatic logic [4:0] pal_index(input logic [14:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[1:0] == 2'b00) i[4] = 1'b0;
    return i;
  endfunction

  function automatic logic [10:0] nt_index(input logic [14:0] a, input logic [1:0] mir);
    logic tbl;
    case (mir)
      2'd0: tbl = 1'b0;
      2'd1: tbl = 1'b1;
      2'd2: tbl = a[10];
      default: tbl = a[11];
    endcase
    return {tbl, a[9:0]};
  endfunction
endpackage
`default_nettype wire

@@ src/puregp_if.sv @@
`default_nettype none
interface puregp_req_if;
  logic valid;
  logic ready;
  puregp_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface puregp_rsp_if;
  logic valid;
  logic ready;
  puregp_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface puregp_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/puregp_mem.sv @@
`default_nettype none
module puregp_mem (
  input  wire logic              clk_i,
  input  wire puregp_pkg::memreq_t req_i,
  output logic [7:0]             oam_rdata_o,
  output logic [7:0]             nt_rdata_o,
  output logic [7:0]             pal_rdata_o
);
  import puregp_pkg::*;
  // contents undefined until swept by the sequencer after reset
  logic [7:0] oam_mem [256];
  logic [7:0] nt_mem  [2048];
  logic [7:0] pal_mem [32];

  always_ff @(posedge clk_i) begin
    if (req_i.oam_we) oam_mem[req_i.sprite_addr] <= req_i.wdata;
    oam_rdata_o <= oam_mem[req_i.sprite_addr];
  end
  always_ff @(posedge clk_i) begin
    if (req_i.nt_we) nt_mem[req_i.nt_addr] <= req_i.wdata;
    nt_rdata_o <= nt_mem[req_i.nt_addr];
  end
  always_ff @(posedge clk_i) begin
    if (req_i.pal_we) pal_mem[req_i.pal_addr] <= req_i.wdata;
    pal_rdata_o <= pal_mem[req_i.pal_addr];
  end
endmodule
`default_nettype wire

@@ src/puregp_timing.sv @@
`default_nettype none
module puregp_timing (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       rendering_i,
  output logic [8:0]      dot_o,
  output logic [8:0]      line_o,
  output logic            odd_o,
  output logic            vset_o,
  output logic            vclr_o,
  output logic            reload_o
);
  import puregp_pkg::*;
  logic [8:0] dot_q, dot_d, line_q, line_d;
  logic odd_q, odd_d;

  // one dot per step; the sequencer issues three steps per CPU tick
  always_comb begin
    dot_d = dot_q; line_d = line_q; odd_d = odd_q;
    if (rendering_i && odd_q && line_q == PRE_LINE && dot_q == SKIP_DOT) begin
      dot_d = '0; line_d = '0; odd_d = ~odd_q;
    end else if (dot_q == DOTS_LAST) begin
      dot_d = '0;
      if (line_q == LINES_LAST) begin
        line_d = '0; odd_d = ~odd_q;
      end else begin
        line_d = line_q + 9'd1;
      end
    end else begin
      dot_d = dot_q + 9'd1;
    end
  end

  always_comb begin
    vset_o = line_d == VBLANK_LINE && dot_d == 9'd1;
    vclr_o = line_d == PRE_LINE && dot_d == 9'd1;
    reload_o = rendering_i && line_d == PRE_LINE && dot_d == RELOAD_DOT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; line_q <= '0; odd_q <= 1'b0;
    end else if (step_i) begin
      dot_q <= dot_d; line_q <= line_d; odd_q <= odd_d;
    end
  end
  assign dot_o = dot_q;
  assign line_o = line_q;
  assign odd_o = odd_q;
endmodule
`default_nettype wire

@@ src/picture_unit_register_port_unit.sv @@
// Picture-unit register port.
// Channels: req (func, register_select, write_data, pattern_data,
// nametable_mirroring) in, rsp (read_data, nmi_request, vram_address,
// scanline, dot, frame parity) out, one result beat per request beat, and
// cfg carrying startup_block_cycles.
// A register item runs through accept, memory read (synchronous RAMs
// for OAM, nametable and palette), update and write-back, then loading
// the response register. The result beat is offered from the response
// register loaded in the FIN state, after the READ and EXEC states. A tick
// repeats the read and the update state to step the dot counter three
// times. The next request is taken while the response still waits,
// once the sequencer is back to idle; no new request is taken before the
// sequencer is through with the last one.
// After reset a clearing sweep over 2048 addresses zeroes all three memories;
// no request is taken during it, cfg writes are taken at all times.
// A stalled receiver holds the response register; if a second result is
// finished while the first waits, the sequencer holds it and the request
// side stalls.
`default_nettype none
module picture_unit_register_port_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  puregp_req_if.sink   req,
  puregp_rsp_if.source rsp,
  puregp_cfg_if.sink   cfg
);
  import puregp_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]  st_q;
  logic [10:0] clr_q;
  logic [1:0]  tick_q;
  req_t        r_q;
  logic [15:0] blk_q, cnt_q;
  logic [7:0]  ctrl_q, mask_q, buf_q, sidx_q, rd_q;
  logic        vbl_q, nmi_q, tog_q;
  logic [14:0] t_q, v_q;
  rsp_t        out_q;
  logic        out_vld_q;

  memreq_t mreq;
  logic [7:0] oam_rd, nt_rd, pal_rd;
  logic [8:0] dot, line;
  logic odd, vset, vclr, reload, step, rendering;
  logic fin_load;

  assign rendering = mask_q[3] | mask_q[4];
  assign cfg.ready = 1'b1;
  assign req.ready = (st_q == ST_IDLE);
  assign rsp.valid = out_vld_q;
  assign rsp.payload = out_q;
  // hand the finished result over once the response register is free
  assign fin_load = (st_q == ST_FIN) && (!out_vld_q || rsp.ready);

  // address used for the memory read of this item
  logic [14:0] a14, nt_a;
  assign a14 = {1'b0, v_q[13:0]};
  assign nt_a = (a14 >= 15'h3F00) ? a14 - 15'h1000 : a14;

  always_comb begin
    mreq = '0;
    mreq.sprite_addr = sidx_q;
    mreq.nt_addr = nt_index(nt_a, r_q.nametable_mirroring);
    mreq.pal_addr = pal_index(a14);
    mreq.wdata = r_q.write_data;
    if (st_q == ST_CLEAR) begin
      mreq.wdata = '0;
      mreq.sprite_addr = clr_q[7:0];
      mreq.nt_addr = clr_q;
      mreq.pal_addr = clr_q[4:0];
      mreq.oam_we = 1'b1; mreq.nt_we = 1'b1; mreq.pal_we = 1'b1;
    end else if (st_q == ST_EXEC && r_q.func == FUNC_WRITE) begin
      if (r_q.register_select == REG_ODATA) mreq.oam_we = 1'b1;
      if (r_q.register_select == REG_DATA) begin
        if (a14 >= 15'h3F00) mreq.pal_we = 1'b1;
        else if (a14 >= 15'h2000) mreq.nt_we = 1'b1;
      end
    end
  end

  puregp_mem u_mem (
    .clk_i, .req_i(mreq),
    .oam_rdata_o(oam_rd), .nt_rdata_o(nt_rd), .pal_rdata_o(pal_rd)
  );

  assign step = (st_q == ST_READ || st_q == ST_EXEC) && r_q.func == FUNC_TICK && tick_q != 2'd3;

  puregp_timing u_tim (
    .clk_i, .rst_ni, .step_i(step), .rendering_i(rendering),
    .dot_o(dot), .line_o(line), .odd_o(odd),
    .vset_o(vset), .vclr_o(vclr), .reload_o(reload)
  );

  logic blocked;
  logic [14:0] inc;
  assign blocked = cnt_q < blk_q;
  assign inc = ctrl_q[2] ? 15'd32 : 15'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0; tick_q <= '0;
      blk_q <= STARTUP_DEFAULT; cnt_q <= '0;
      ctrl_q <= '0; mask_q <= '0; buf_q <= '0; sidx_q <= '0; rd_q <= '0;
      vbl_q <= 1'b0; nmi_q <= 1'b0; tog_q <= 1'b0;
      t_q <= '0; v_q <= '0; out_vld_q <= 1'b0;
      r_q <= '0; out_q <= '0;
    end else begin
      if (cfg.valid) blk_q <= cfg.payload;
      if (fin_load) out_vld_q <= 1'b1;
      else if (rsp.ready) out_vld_q <= 1'b0;
      if (step) begin
        tick_q <= tick_q + 2'd1;
        if (vset) begin
          vbl_q <= 1'b1;
          if (ctrl_q[7]) nmi_q <= 1'b1;
        end else if (vclr) vbl_q <= 1'b0;
        else if (reload) v_q <= t_q;
      end
      case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 11'd1;
          if (clr_q == 11'd2047) st_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            r_q <= req.payload;
            tick_q <= '0;
            rd_q <= '0;
            st_q <= ST_READ;
          end
        end
        ST_READ: begin
          // tick items loop here until two dots are done
          if (r_q.func != FUNC_TICK || tick_q == 2'd1) st_q <= ST_EXEC;
        end
        ST_EXEC: begin
          case (r_q.func)
            FUNC_READ: begin
              case (r_q.register_select)
                REG_STATUS: begin
                  rd_q <= {vbl_q, 7'd0};
                  vbl_q <= 1'b0; tog_q <= 1'b0; nmi_q <= 1'b0;
                end
                REG_ODATA: rd_q <= oam_rd;
                REG_DATA: begin
                  if (a14 >= 15'h3F00) begin
                    rd_q <= pal_rd; buf_q <= nt_rd;
                  end else begin
                    rd_q <= buf_q;
                    buf_q <= (a14 < 15'h2000) ? r_q.pattern_data : nt_rd;
                  end
                  v_q <= v_q + inc;
                end
                default: ;
              endcase
            end
            FUNC_WRITE: begin
              case (r_q.register_select)
                REG_CTRL: if (!blocked) begin
                  if (r_q.write_data[7] && !ctrl_q[7] && vbl_q) nmi_q <= 1'b1;
                  ctrl_q <= r_q.write_data;
                  t_q[11:10] <= r_q.write_data[1:0];
                end
                REG_MASK: if (!blocked) mask_q <= r_q.write_data;
                REG_OADDR: sidx_q <= r_q.write_data;
                REG_ODATA: sidx_q <= sidx_q + 8'd1;
                REG_SCROLL: if (!blocked) begin
                  if (!tog_q) t_q[4:0] <= r_q.write_data[7:3];
                  else begin
                    t_q[14:12] <= r_q.write_data[2:0];
                    t_q[9:5] <= r_q.write_data[7:3];
                  end
                  tog_q <= ~tog_q;
                end
                REG_ADDR: if (!blocked) begin
                  if (!tog_q) begin
                    t_q[14] <= 1'b0; t_q[13:8] <= r_q.write_data[5:0];
                  end else begin
                    t_q[7:0] <= r_q.write_data;
                    v_q <= {t_q[14:8], r_q.write_data};
                  end
                  tog_q <= ~tog_q;
                end
                REG_DATA: v_q <= v_q + inc;
                default: ;
              endcase
            end
            FUNC_TICK: begin
              if (!step) begin
                if (blocked) cnt_q <= cnt_q + 16'd1;
              end
            end
            default: nmi_q <= 1'b0;
          endcase
          if (r_q.func != FUNC_TICK || !step) begin
            st_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold here while the previous result still waits
          if (fin_load) begin
            out_q.read_data <= rd_q;
            out_q.nmi_request <= nmi_q;
            out_q.vram_address <= v_q;
            out_q.scanline <= line;
            out_q.dot <= dot;
            out_q.parity <= odd;
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
